// ===== src/tica_pkg.sv =====
// types and constants shared by the table id chunk allocator modules
// no dependencies
package tica_pkg;

  // input item kinds
  localparam logic [1:0] MODE_ASSIGN  = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_REL_ALL = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_NOT_REL   = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // register index, taken from paddr bit 2
  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_END   = 1'b1;

  localparam logic [31:0] ID_AUTO_MIN = 32'd1;
  localparam logic [31:0] ID_COMPAT   = 32'd252;
  localparam logic [31:0] ID_LOCAL    = 32'd255;
  localparam logic [31:0] ID_MAX      = 32'hffffffff;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] last;
    logic [7:0]  proto;
    logic [15:0] inst;
  } entry_t;

  typedef struct packed {
    logic        manual;
    logic [31:0] range_start;
    logic [31:0] range_end;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  proto;
    logic [15:0] inst;
    logic [31:0] size;
    logic [31:0] rel_start;
    logic [31:0] rel_end;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first;
    logic [31:0] last;
    logic        reused;
    logic [6:0]  rel_count;
  } res_t;

endpackage

// ===== src/table_id_chunk_allocator_top.sv =====
// Table id chunk allocator: hands out contiguous ranges of 32-bit table ids to owners.
// Input item (in_): kind in tuser, owner and ids in tdata; one result item per input item (out_).
// Two configuration registers on an APB-style port: range_start at 0x0, range_end at 0x4.
// Both zero selects automatic ranges (start at 1; a request of more than 251 ids made below id 252 starts at 256).
// Each item is worked on alone; in_tready is high only while the sequencer is idle.
// An item scans the chunk table one entry a cycle through the single read port of the
// table memory (release, release-all, reuse); appending a new chunk then passes through
// the start and check states before the result is taken.
// Mode 3 items skip the scan and go straight to the finish state.
// The result goes to an output register; the next item is accepted while it waits.
// If the receiver stalls with a result still held, a finished item waits in the sequencer.
// Reset clears the chunk count, the registers and the handshakes; the table memory is not
// cleared, since only entries below the chunk count are ever read.
// depends on tica_pkg, tica_ram, tica_cmp, tica_seq
module table_id_chunk_allocator_top import tica_pkg::*; #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // owner_proto[7:0], owner_instance[23:8], req_size[55:24], rel_start[87:56],
  // rel_end[119:88]
  input  logic [119:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // chunk_first[31:0], chunk_last[63:32], reused[64], released_count[71:65]
  output logic [71:0]  out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CW = $clog2(MAX_CHUNKS + 1);

  logic [31:0] range_start_r, range_start_nxt;
  logic [31:0] range_end_r, range_end_nxt;
  logic        cfg_wr;
  cfg_t        cfg;
  req_t        in_req;
  res_t        out_res;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    range_start_nxt = range_start_r;
    range_end_nxt   = range_end_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_RANGE_START: range_start_nxt = cfg_pwdata;
        REG_RANGE_END:   range_end_nxt   = cfg_pwdata;
        default:         range_start_nxt = range_start_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_RANGE_START: cfg_prdata = range_start_r;
      REG_RANGE_END:   cfg_prdata = range_end_r;
      default:         cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= 32'd0;
      range_end_r   <= 32'd0;
    end else begin
      range_start_r <= range_start_nxt;
      range_end_r   <= range_end_nxt;
    end
  end

  assign cfg.manual      = (range_start_r != 32'd0) || (range_end_r != 32'd0);
  assign cfg.range_start = range_start_r;
  assign cfg.range_end   = range_end_r;

  assign in_req.mode      = in_tuser;
  assign in_req.proto     = in_tdata[7:0];
  assign in_req.inst      = in_tdata[23:8];
  assign in_req.size      = in_tdata[55:24];
  assign in_req.rel_start = in_tdata[87:56];
  assign in_req.rel_end   = in_tdata[119:88];

  tica_ram #(
    .DEPTH (MAX_CHUNKS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tica_seq #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .IW         (IW),
    .CW         (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  assign out_tuser        = out_res.status;
  assign out_tdata[31:0]  = out_res.first;
  assign out_tdata[63:32] = out_res.last;
  assign out_tdata[64]    = out_res.reused;
  assign out_tdata[71:65] = out_res.rel_count;

endmodule

// ===== src/tica_ram.sv =====
// chunk table memory: one write port, one registered read port
// depends on tica_pkg
module tica_ram import tica_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tica_cmp.sv =====
// shared id arithmetic: (a - b + 1) mod 2^32 compared against c
// used for chunk size match while scanning and for the exhaustion check
module tica_cmp (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        eq,
  output logic        lt
);

  logic [31:0] diff;

  assign diff = a - b + 32'd1;
  assign eq   = (diff == c);
  assign lt   = (diff < c);

endmodule

// ===== src/tica_seq.sv =====
// request sequencer: scans the chunk table one entry a cycle, appends chunks,
// holds the result register; depends on tica_pkg and tica_cmp
module tica_seq import tica_pkg::*; #(
  parameter int MAX_CHUNKS = 64,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  req_t          in_req,
  input  cfg_t          cfg,
  output logic          out_valid,
  input  logic          out_ready,
  output res_t          out_res,
  output logic          ram_we,
  output logic [IW-1:0] ram_waddr,
  output entry_t        ram_wdata,
  output logic [IW-1:0] ram_raddr,
  input  entry_t        ram_rdata
);

  localparam int TW = (CW > 7) ? CW : 7;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_START = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  req_t          req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [IW-1:0] chk_r, chk_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [CW-1:0] rel_cnt_r, rel_cnt_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [31:0]   last_end_r, last_end_nxt;
  res_t          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  logic          issuing;
  logic          scan_end;
  logic          own_hit;
  logic          free_hit;
  logic          rel_hit;
  logic [CW-1:0] rel_cnt_inc;
  logic [TW-1:0] rel_cnt_wide;
  logic [31:0]   u_a, u_b, u_c;
  logic          u_eq, u_lt;
  logic [31:0]   base;
  logic [31:0]   new_last;

  tica_cmp u_cmp (
    .a  (u_a),
    .b  (u_b),
    .c  (u_c),
    .eq (u_eq),
    .lt (u_lt)
  );

  always_comb begin
    if (state_r == ST_CHECK) begin
      u_a = cfg.manual ? cfg.range_end : ID_MAX;
      u_b = req_r.size;
      u_c = start_r;
    end else begin
      u_a = ram_rdata.last;
      u_b = ram_rdata.first;
      u_c = req_r.size;
    end
  end

  assign issuing  = (state_r == ST_SCAN) && (iss_r < cnt_r);
  // no reads left to issue: the item in flight, if any, is the last one
  assign scan_end = (iss_r == cnt_r);
  assign own_hit  = chk_vld_r && (ram_rdata.proto == req_r.proto) &&
                    (ram_rdata.inst == req_r.inst);
  assign free_hit = chk_vld_r && (ram_rdata.proto == 8'd0) && u_eq;
  assign rel_hit  = own_hit && (ram_rdata.first == req_r.rel_start) &&
                    (ram_rdata.last == req_r.rel_end);
  assign rel_cnt_inc  = own_hit ? rel_cnt_r + CW'(1) : rel_cnt_r;
  assign rel_cnt_wide = TW'(rel_cnt_inc);
  assign new_last     = start_r + req_r.size - 32'd1;
  assign ram_raddr    = iss_r[IW-1:0];

  always_comb begin
    if (cnt_r == '0) begin
      base = cfg.manual ? cfg.range_start : ID_AUTO_MIN;
    end else begin
      base = last_end_r + 32'd1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    chk_nxt       = chk_r;
    chk_vld_nxt   = chk_vld_r;
    rel_cnt_nxt   = rel_cnt_r;
    start_nxt     = start_r;
    last_end_nxt  = last_end_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_r;
    ram_wdata     = '{first: ram_rdata.first, last: ram_rdata.last,
                      proto: 8'd0, inst: 16'd0};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_req;
          iss_nxt     = '0;
          chk_vld_nxt = 1'b0;
          rel_cnt_nxt = '0;
          res_nxt     = '0;
          state_nxt   = (in_req.mode == MODE_NONE) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        chk_vld_nxt = issuing;
        chk_nxt     = iss_r[IW-1:0];
        if (issuing) begin
          iss_nxt = iss_r + CW'(1);
        end
        case (req_r.mode)
          MODE_ASSIGN: begin
            if (free_hit) begin
              ram_we          = 1'b1;
              ram_wdata.proto = req_r.proto;
              ram_wdata.inst  = req_r.inst;
              res_nxt.first   = ram_rdata.first;
              res_nxt.last    = ram_rdata.last;
              res_nxt.reused  = 1'b1;
              chk_vld_nxt     = 1'b0;
              state_nxt       = ST_FIN;
            end else if (scan_end) begin
              if (cnt_r == CW'(MAX_CHUNKS)) begin
                res_nxt.status = STATUS_FULL;
                state_nxt      = ST_FIN;
              end else begin
                state_nxt = ST_START;
              end
            end
          end
          MODE_RELEASE: begin
            if (rel_hit) begin
              ram_we      = 1'b1;
              chk_vld_nxt = 1'b0;
              state_nxt   = ST_FIN;
            end else if (scan_end) begin
              res_nxt.status = STATUS_NOT_REL;
              state_nxt      = ST_FIN;
            end
          end
          MODE_REL_ALL: begin
            ram_we      = own_hit;
            rel_cnt_nxt = rel_cnt_inc;
            if (scan_end) begin
              res_nxt.rel_count = rel_cnt_wide[6:0];
              state_nxt         = ST_FIN;
            end
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_START: begin
        // automatic mode: a request larger than 251 ids with a base below 252 starts at 256
        if (!cfg.manual && (base < ID_COMPAT) &&
            (req_r.size > (ID_COMPAT - ID_AUTO_MIN))) begin
          start_nxt = ID_LOCAL + 32'd1;
        end else begin
          start_nxt = base;
        end
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (u_lt) begin
          res_nxt.status = STATUS_EXHAUSTED;
        end else begin
          ram_we        = 1'b1;
          ram_waddr     = cnt_r[IW-1:0];
          ram_wdata     = '{first: start_r, last: new_last,
                            proto: req_r.proto, inst: req_r.inst};
          last_end_nxt  = new_last;
          cnt_nxt       = cnt_r + CW'(1);
          res_nxt.first = start_r;
          res_nxt.last  = new_last;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
      rel_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
      rel_cnt_r   <= rel_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    chk_r      <= chk_nxt;
    start_r    <= start_nxt;
    last_end_r <= last_end_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_CHUNKS))
    else $error("chunk count beyond table depth");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_SCAN || state_r == ST_CHECK))
    else $error("table write outside scan or append");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted item did not start");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("chunk count moved by more than one");
`endif

endmodule
